/* rtl/dmc_pkg.sv */
package dmc_pkg;

  // Word address width of main memory, fixed by the request format.
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 32;

  // Request codes.
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Access cost added to the cycle counter.
  localparam logic [CNT_W-1:0] HIT_CYCLES  = 32'd2;
  localparam logic [CNT_W-1:0] MISS_CYCLES = 32'd100;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_data;
  } dmc_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     hit;
    logic [CNT_W-1:0]         total_cycles;
    logic [CNT_W-1:0]         miss_count;
  } dmc_res_t;

endpackage

/* rtl/dmc_ram.sv */
module dmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/direct_mapped_cache_write_through.sv */
// Channel   Ports                  Transfer
// request   start, busy, request   edge with start high and busy low
// result    done, result           edge that ends the one cycle done is high
//
// For each request the tag and memory reads are issued when it is taken, and
// the result, the counter update and any write happen on the following edge.
// busy stays high while a request is in flight, so a new request is taken only
// once the one before has finished. After reset the main memory is zeroed one
// word a cycle, all 2^ADDR_W = 2048 words, with busy high. The receiver cannot stall results.
module direct_mapped_cache_write_through #(
  parameter int unsigned INDEX_BITS  = 3,
  parameter int unsigned OFFSET_BITS = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dmc_pkg::dmc_req_t request,
  output logic              busy,
  output logic              done,
  output dmc_pkg::dmc_res_t result
);

  import dmc_pkg::*;

  localparam int unsigned NUM_LINES = 1 << INDEX_BITS;
  localparam int unsigned TAG_BITS  = ADDR_W - INDEX_BITS - OFFSET_BITS;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

  // Control and payload registers.
  logic                  clearing;
  logic [ADDR_W-1:0]     clr_addr;
  logic                  pending;
  dmc_req_t              req_q;
  logic [NUM_LINES-1:0]  line_valid;
  logic [CNT_W-1:0]      cycle_count;
  logic [CNT_W-1:0]      miss_cnt;

  logic                  accept;
  logic [INDEX_BITS-1:0] rd_index;
  logic [INDEX_BITS-1:0] idx;
  logic [TAG_BITS-1:0]   tag;
  logic [TAG_BITS-1:0]   tag_rdata;
  logic [DATA_W-1:0]     mem_rdata;
  logic                  is_hit;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DATA_W-1:0]     mem_wdata;
  logic                  tag_we;
  logic [CNT_W-1:0]      cycle_count_next;
  logic [CNT_W-1:0]      miss_cnt_next;
  dmc_res_t              result_next;

  assign busy   = clearing | pending;
  assign accept = start & ~busy;

  // Lookup fields of the request being taken and of the one in flight.
  assign rd_index = request.address[OFFSET_BITS +: INDEX_BITS];
  assign idx      = req_q.address[OFFSET_BITS +: INDEX_BITS];
  assign tag      = req_q.address[ADDR_W-1 -: TAG_BITS];
  assign is_hit   = line_valid[idx] & (tag_rdata == tag);

  // Tag store, one entry per line.
  dmc_ram #(
    .WIDTH(TAG_BITS),
    .DEPTH(NUM_LINES)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(idx),
    .wdata(tag),
    .raddr(rd_index),
    .rdata(tag_rdata)
  );

  // Main memory. A write refills its whole line from memory, so every word
  // of a valid line equals memory and a hit returns the memory word as well.
  dmc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MEM_DEPTH)
  ) u_main_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(request.address),
    .rdata(mem_rdata)
  );

  // Write port: the clearing pass owns it after reset, then write requests.
  always_comb begin
    tag_we = pending & (req_q.req_type == REQ_WRITE);
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = tag_we;
      mem_waddr = req_q.address;
      mem_wdata = req_q.write_data;
    end
  end

  // Counter update and result word for the request in flight.
  always_comb begin
    cycle_count_next = cycle_count;
    miss_cnt_next    = miss_cnt;
    result_next      = '0;
    case (req_q.req_type)
      REQ_READ: begin
        result_next.read_data = mem_rdata;
        result_next.hit       = is_hit;
        if (is_hit) begin
          cycle_count_next = cycle_count + HIT_CYCLES;
        end else begin
          cycle_count_next = cycle_count + MISS_CYCLES;
          miss_cnt_next    = miss_cnt + 1'b1;
        end
      end
      REQ_CLEAR: begin
        cycle_count_next = '0;
        miss_cnt_next    = '0;
      end
      default: begin
      end
    endcase
    result_next.total_cycles = cycle_count_next;
    result_next.miss_count   = miss_cnt_next;
  end

  // Sequencing, valid bits, counters and the done strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_addr    <= '0;
      pending     <= 1'b0;
      done        <= 1'b0;
      line_valid  <= '0;
      cycle_count <= '0;
      miss_cnt    <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) begin
          clearing <= 1'b0;
        end
      end
      pending <= accept;
      done    <= pending;
      if (pending) begin
        cycle_count <= cycle_count_next;
        miss_cnt    <= miss_cnt_next;
        if (tag_we) begin
          line_valid[idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    if (pending) begin
      result <= result_next;
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  localparam int NUM_LINES   = 8;
  localparam int LINE_WORDS  = 4;
  localparam int MEM_WORDS   = 1 << ADDR_W;
  localparam int RANDOM_REQS = 1030;
  localparam int LATE_REQS   = 150;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  dmc_req_t request;
  dmc_res_t result;

  direct_mapped_cache_write_through u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Mirror of the cache, the backing memory and the two counters.
  logic [5:0]        tag_mirror   [NUM_LINES];
  logic              valid_mirror [NUM_LINES];
  logic [DATA_W-1:0] word_mirror  [NUM_LINES*LINE_WORDS];
  logic [DATA_W-1:0] mem_mirror   [MEM_WORDS];
  logic [CNT_W-1:0]  cycle_total;
  logic [CNT_W-1:0]  miss_total;

  dmc_req_t pending_reqs[$];
  dmc_res_t expected_results[$];
  logic     xfer_taken = 1'b0;
  int       gap_left = 0;
  int       err_count = 0;
  int       cycle_count = 0;

  // Apply one request to the mirror and return the result it should produce.
  function automatic dmc_res_t cache_access(input dmc_req_t r);
    dmc_res_t          res;
    logic [2:0]        idx;
    logic [ADDR_W-1:0] base;
    res = '0;
    idx = r.address[4:2];
    base = {r.address[ADDR_W-1:2], 2'b00};
    case (r.req_type)
      REQ_READ: begin
        if (valid_mirror[idx] && tag_mirror[idx] == r.address[ADDR_W-1:5]) begin
          res.read_data = word_mirror[{idx, r.address[1:0]}];
          res.hit = 1'b1;
          cycle_total += HIT_CYCLES;
        end else begin
          res.read_data = mem_mirror[r.address];
          cycle_total += MISS_CYCLES;
          miss_total += 1;
        end
      end
      REQ_WRITE: begin
        // Write-through, then the whole line is refilled from memory.
        mem_mirror[r.address] = r.write_data;
        for (int k = 0; k < LINE_WORDS; k++) begin
          word_mirror[{idx, k[1:0]}] = mem_mirror[base + ADDR_W'(k)];
        end
        tag_mirror[idx] = r.address[ADDR_W-1:5];
        valid_mirror[idx] = 1'b1;
      end
      REQ_CLEAR: begin
        cycle_total = '0;
        miss_total = '0;
      end
      default: ;
    endcase
    res.total_cycles = cycle_total;
    res.miss_count = miss_total;
    return res;
  endfunction

  task automatic add_req(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] data);
    dmc_req_t r;
    r.req_type = kind;
    r.address = addr;
    r.write_data = data;
    pending_reqs.push_back(r);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reset, released on a falling clock edge.
  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Request driver: a new transfer is presented once the previous one was taken, at times after a random gap.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || xfer_taken) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        request <= pending_reqs.pop_front();
        start <= 1'b1;
        if (pending_reqs.size() > LATE_REQS && $urandom_range(0, 3) == 0) begin
          gap_left <= $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result strobe, then record a newly accepted request.
  always @(posedge clk) begin : monitor
    dmc_res_t want;
    xfer_taken <= !rst && start && !busy;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, result.read_data);
          err_count++;
        end
        if (result.hit !== want.hit) begin
          $error("hit: expected %b, got %b", want.hit, result.hit);
          err_count++;
        end
        if (result.total_cycles !== want.total_cycles) begin
          $error("total_cycles: expected %0d, got %0d", want.total_cycles,
                 result.total_cycles);
          err_count++;
        end
        if (result.miss_count !== want.miss_count) begin
          $error("miss_count: expected %0d, got %0d", want.miss_count, result.miss_count);
          err_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      expected_results.push_back(cache_access(request));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int                roll;
    for (int i = 0; i < NUM_LINES; i++) begin
      tag_mirror[i] = '0;
      valid_mirror[i] = 1'b0;
    end
    for (int i = 0; i < NUM_LINES*LINE_WORDS; i++) word_mirror[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) mem_mirror[i] = '0;
    cycle_total = '0;
    miss_total = '0;

    // Directed: cold miss, allocation on write, hits on refilled words,
    // eviction by a conflicting tag, clearing and the data extremes.
    add_req(REQ_READ,  11'd0,    32'h0);
    add_req(REQ_WRITE, 11'd0,    32'h7FFF_FFFF);
    add_req(REQ_READ,  11'd0,    32'h0);
    add_req(REQ_READ,  11'd3,    32'h0);
    add_req(REQ_WRITE, 11'd2047, 32'h8000_0000);
    add_req(REQ_READ,  11'd2047, 32'h0);
    add_req(REQ_READ,  11'd2044, 32'h0);
    add_req(REQ_WRITE, 11'd1,    32'hFFFF_FFFF);
    add_req(REQ_READ,  11'd1,    32'h0);
    add_req(REQ_READ,  11'd33,   32'h0);
    add_req(REQ_WRITE, 11'd33,   32'hAAAA_AAAA);
    add_req(REQ_READ,  11'd1,    32'h0);
    add_req(REQ_READ,  11'd33,   32'h0);
    add_req(REQ_WRITE, 11'd1365, 32'h5555_5555);
    add_req(REQ_READ,  11'd1365, 32'hFFFF_FFFF);
    add_req(REQ_CLEAR, 11'd2047, 32'hFFFF_FFFF);
    add_req(REQ_READ,  11'd1365, 32'h0);
    add_req(REQ_READ,  11'd2016, 32'h0);
    add_req(REQ_WRITE, 11'd2,    32'h0);
    add_req(REQ_READ,  11'd2,    32'h0);

    // Random: mostly a small set of tags so that lines are reused and hit.
    repeat (RANDOM_REQS) begin
      roll = $urandom_range(0, 99);
      if (roll <= 45) kind = REQ_READ;
      else if (roll <= 96) kind = REQ_WRITE;
      else kind = REQ_CLEAR;
      if ($urandom_range(0, 9) < 7) addr[ADDR_W-1:5] = 6'($urandom_range(0, 3));
      else addr[ADDR_W-1:5] = 6'($urandom_range(0, 63));
      addr[4:0] = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 15))
        0:       data = 32'h0;
        1:       data = 32'hFFFF_FFFF;
        2:       data = 32'h8000_0000;
        3:       data = 32'h7FFF_FFFF;
        default: data = $urandom;
      endcase
      add_req(kind, addr, data);
    end

    while (pending_reqs.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
